[rtl/bud_pkg.sv]
`default_nettype none

package bud_pkg;

    // frame phase codes
    localparam logic [1:0] PH_WAIT  = 2'd0;
    localparam logic [1:0] PH_FRAME = 2'd1;
    localparam logic [1:0] PH_ESC   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUF_END  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_SHORT    = 2'd3;

    // register indexes (byte address bits [4:2])
    localparam logic [2:0] REG_START  = 3'd0;
    localparam logic [2:0] REG_STOP   = 3'd1;
    localparam logic [2:0] REG_ESCAPE = 3'd2;
    localparam logic [2:0] REG_OFFSET = 3'd3;
    localparam logic [2:0] REG_HEADER = 3'd4;

    // register reset values
    localparam logic [7:0] RST_START  = 8'd2;
    localparam logic [7:0] RST_STOP   = 8'd3;
    localparam logic [7:0] RST_ESCAPE = 8'd16;
    localparam logic [7:0] RST_OFFSET = 8'd32;
    localparam logic [7:0] RST_HEADER = 8'd8;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] stop_byte;
        logic [7:0] escape_byte;
        logic [7:0] escape_offset;
        logic [7:0] header_bytes;
    } cfg_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] data_byte;
        logic       data_valid;
        logic [7:0] byte_index;
        logic       frame_done;
        logic [8:0] frame_bytes;
        logic [8:0] payload_len;
        logic [1:0] status;
    } res_t;

endpackage

`default_nettype wire

[rtl/bud_decode.sv]
`default_nettype none

module bud_decode #(
    parameter int MAX_FRAME = 256,
    parameter int CNT_W     = 9
) (
    input  wire bud_pkg::cfg_t   cfg,
    input  wire [1:0]            phase,
    input  wire [CNT_W-1:0]      count,
    input  wire [7:0]            rx_byte,
    input  wire                  buffer_end,
    output logic [1:0]           phase_next,
    output logic [CNT_W-1:0]     count_next,
    output bud_pkg::res_t        res
);
    import bud_pkg::*;

    localparam int CW = (CNT_W > 9) ? CNT_W : 9;
    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_FRAME);

    logic [CW-1:0] count_ext;
    logic [CW-1:0] header_ext;
    logic [CW-1:0] diff;
    logic          store;
    logic [7:0]    store_byte;

    assign count_ext  = CW'(count);
    assign header_ext = CW'(cfg.header_bytes);
    assign diff       = count_ext - header_ext;

    always_comb begin
        phase_next = phase;
        count_next = count;
        store      = 1'b0;
        store_byte = rx_byte;
        res        = '0;

        // phase decode, stop tested before escape
        case (phase)
            PH_FRAME: begin
                if (rx_byte == cfg.stop_byte) begin
                    res.emit        = 1'b1;
                    res.frame_done  = 1'b1;
                    res.frame_bytes = count_ext[8:0];
                    if (count_ext < header_ext) begin
                        res.status = ST_SHORT;
                    end else begin
                        res.payload_len = diff[8:0];
                    end
                    phase_next = PH_WAIT;
                    count_next = '0;
                end else if (rx_byte == cfg.escape_byte) begin
                    phase_next = PH_ESC;
                end else begin
                    store = 1'b1;
                end
            end
            PH_ESC: begin
                store      = 1'b1;
                store_byte = rx_byte - cfg.escape_offset;
                phase_next = PH_FRAME;
            end
            default: begin
                phase_next = PH_WAIT;
                if (rx_byte == cfg.start_byte) begin
                    phase_next = PH_FRAME;
                    count_next = '0;
                end
            end
        endcase

        // store into the frame, count saturates when full
        if (store) begin
            res.emit = 1'b1;
            if (count == COUNT_MAX) begin
                res.status = ST_OVERFLOW;
            end else begin
                res.data_valid = 1'b1;
                res.data_byte  = store_byte;
                res.byte_index = count_ext[7:0];
                count_next     = count + 1'b1;
            end
        end

        // buffer ran out with the frame still open
        if (buffer_end && (phase_next != PH_WAIT)) begin
            res.emit   = 1'b1;
            res.status = ST_BUF_END;
            phase_next = PH_WAIT;
            count_next = '0;
        end
    end

endmodule

`default_nettype wire

[rtl/byte_unstuffing_deframer.sv]
`default_nettype none

// Byte-unstuffing deframer. Takes one received byte per transaction on the s_ side and
// gives at most one result per byte on the m_ side: an unstuffed frame byte with its
// index, a frame-closed report with byte count and payload length, or an error status.
// A new byte can be accepted every cycle while s_tready is high, that is while the result
// register is empty or being taken in the same cycle; the decode is a single pass of logic
// between the phase/count registers and the result register. The user must set control
// bytes and header size through the APB port only while the block is idle; it is not enforced.

module byte_unstuffing_deframer #(
    parameter int MAX_FRAME = 256
) (
    input  wire         aclk,
    input  wire         aresetn,
    // input channel
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [7:0]   s_tdata,   // [7:0] rx_byte
    input  wire         s_tlast,   // buffer_end
    // result channel
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // [7:0] data_byte, [15:8] byte_index,
                                   // [24:16] frame_bytes, [33:25] payload_len, zero pad
    output logic        m_tlast,   // frame_done
    output logic [2:0]  m_tuser,   // [0] data_valid, [2:1] status
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [4:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bud_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    cfg_t             cfg_reg;
    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    res_t             res;
    res_t             out_reg;
    logic             out_valid_reg;
    logic             s_accept;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte    <= RST_START;
            cfg_reg.stop_byte     <= RST_STOP;
            cfg_reg.escape_byte   <= RST_ESCAPE;
            cfg_reg.escape_offset <= RST_OFFSET;
            cfg_reg.header_bytes  <= RST_HEADER;
        end else if (cfg_write) begin
            case (paddr[4:2])
                REG_START:  cfg_reg.start_byte    <= pwdata[7:0];
                REG_STOP:   cfg_reg.stop_byte     <= pwdata[7:0];
                REG_ESCAPE: cfg_reg.escape_byte   <= pwdata[7:0];
                REG_OFFSET: cfg_reg.escape_offset <= pwdata[7:0];
                REG_HEADER: cfg_reg.header_bytes  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[4:2])
            REG_START:  prdata = {24'd0, cfg_reg.start_byte};
            REG_STOP:   prdata = {24'd0, cfg_reg.stop_byte};
            REG_ESCAPE: prdata = {24'd0, cfg_reg.escape_byte};
            REG_OFFSET: prdata = {24'd0, cfg_reg.escape_offset};
            REG_HEADER: prdata = {24'd0, cfg_reg.header_bytes};
            default:    prdata = 32'd0;
        endcase
    end

    // byte decode
    bud_decode #(
        .MAX_FRAME (MAX_FRAME),
        .CNT_W     (CNT_W)
    ) u_decode (
        .cfg        (cfg_reg),
        .phase      (phase_reg),
        .count      (count_reg),
        .rx_byte    (s_tdata),
        .buffer_end (s_tlast),
        .phase_next (phase_next),
        .count_next (count_next),
        .res        (res)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT;
            count_reg <= '0;
        end else if (s_accept) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_accept && res.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && res.emit) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.payload_len, out_reg.frame_bytes,
                       out_reg.byte_index, out_reg.data_byte};
    assign m_tlast  = out_reg.frame_done;
    assign m_tuser  = {out_reg.status, out_reg.data_valid};

endmodule

`default_nettype wire

[rtl/bud_checker.sv]
`default_nettype none

module bud_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata,
    input wire        m_tlast,
    input wire [2:0]  m_tuser
);
    import bud_pkg::*;

    // a frame byte never comes with a frame close
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> !m_tlast)
        else $error("data byte and frame close in one transaction");

    // a closed frame reports ok or short only
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |->
            ((m_tuser[2:1] == ST_OK) || (m_tuser[2:1] == ST_SHORT)))
        else $error("frame close with bad status");

    // payload never exceeds the frame count, and is zero on a short frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |->
            ((m_tdata[33:25] <= m_tdata[24:16]) &&
             ((m_tuser[2:1] != ST_SHORT) || (m_tdata[33:25] == 9'd0))))
        else $error("payload length inconsistent with frame count");

    // an overflow drops the byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[2:1] == ST_OVERFLOW)) |-> (!m_tuser[0] && !m_tlast))
        else $error("overflow transaction carries data");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind byte_unstuffing_deframer bud_checker u_bud_checker (.*);

`default_nettype wire
